### rtl/tkl_pkg.sv
package tkl_pkg;

	// keypad geometry in pixels
	localparam int ZonePitch = 90;
	localparam int RowOffset = 15;

	// entry buffer length and the configured part of the code
	localparam int CodeLength = 4;
	localparam int NumCodeRegs = 4;
	localparam int CntW = $clog2(CodeLength + 1);
	localparam int IdxW = (CodeLength > 1) ? $clog2(CodeLength) : 1;
	localparam int CodeIdxW = (NumCodeRegs > 1) ? $clog2(NumCodeRegs) : 1;

	// code positions past the registers are fixed digits, this is the first one
	localparam logic [3:0] ExtraDigitStart = 4'((NumCodeRegs + 1) % 10);

	localparam int XW = 10;
	localparam int YW = 9;
	localparam int KeyW = 4;
	localparam int ActW = 3;
	localparam int CountOutW = 3;

	// configuration port
	localparam int PdataW = 32;
	localparam int PaddrW = CodeIdxW + 2;

	localparam logic [3:0] KeyStar = 4'd10;
	localparam logic [3:0] KeyHash = 4'd11;

	typedef logic [NumCodeRegs-1:0][KeyW-1:0] code_keys_t;

	typedef enum logic [ActW-1:0] {
		ACT_IGNORED = 3'd0,
		ACT_STORED  = 3'd1,
		ACT_QUIT    = 3'd2,
		ACT_DELETE  = 3'd3,
		ACT_CLEAR   = 3'd4,
		ACT_CORRECT = 3'd5,
		ACT_WRONG   = 3'd6
	} act_t;

	typedef enum logic [1:0] {
		BTN_QUIT    = 2'd0,
		BTN_DELETE  = 2'd1,
		BTN_CLEAR   = 2'd2,
		BTN_CONFIRM = 2'd3
	} btn_t;

	typedef struct packed {
		logic            key_hit;
		logic            btn_hit;
		btn_t            btn;
		logic [KeyW-1:0] key;
	} zone_t;

	// key layout: rows 1 2 3 / 4 5 6 / 7 8 9 / * 0 #
	function automatic logic [KeyW-1:0] key_at(input logic [1:0] row, input logic [1:0] col);
		logic [KeyW-1:0] k;
		if (row == 2'd3) begin
			case (col)
				2'd0: k = KeyStar;
				2'd1: k = 4'd0;
				default: k = KeyHash;
			endcase
		end else begin
			k = 4'({2'b00, row} * 4'd3 + {2'b00, col} + 4'd1);
		end
		return k;
	endfunction

	function automatic logic [KeyW-1:0] code_reset(input int pos);
		return 4'((pos + 1) % 10);
	endfunction

endpackage

### rtl/tkl_if.sv
interface tkl_touch_if;
	logic                     valid;
	logic                     ready;
	logic [tkl_pkg::XW-1:0]   touch_x;
	logic [tkl_pkg::YW-1:0]   touch_y;

	modport source(output valid, output touch_x, output touch_y, input ready);
	modport sink(input valid, input touch_x, input touch_y, output ready);
endinterface

interface tkl_result_if;
	logic                          valid;
	logic                          ready;
	logic [tkl_pkg::ActW-1:0]      action;
	logic [tkl_pkg::KeyW-1:0]      key_code;
	logic [tkl_pkg::CountOutW-1:0] entered_count;

	modport source(output valid, output action, output key_code, output entered_count,
		input ready);
	modport sink(input valid, input action, input key_code, input entered_count,
		output ready);
endinterface

### rtl/touch_keypad_code_lock_top.sv
// Touch keypad code lock. Each touch transfer (x, y in pixels) is mapped to a
// zone of a 3-by-4 key grid (1-9, star, 0, hash) at columns 90..359 or to a
// column of quit, delete, clear and confirm buttons at 450..719, rows taken as
// (y + 15) / 90 in 1..4, and gives exactly one result transfer: the action,
// the decoded key and the number of keys held. Up to four keys are buffered;
// confirm compares them with the four code registers (APB, byte addresses
// 0, 4, 8, 12, reset code 1 2 3 4) and any confirm, quit or clear empties the
// buffer. One touch is accepted every cycle unless the input stalls, which it
// does only while a result is held unread; a touch goes through an input
// register and then a result register before its result is offered.
module touch_keypad_code_lock_top (
	input  logic                         clk,
	input  logic                         arst_n,
	tkl_touch_if.sink                    touch,
	tkl_result_if.source                 result,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tkl_pkg::PaddrW-1:0]   paddr,
	input  logic [tkl_pkg::PdataW-1:0]   pwdata,
	output logic [tkl_pkg::PdataW-1:0]   prdata,
	output logic                         pready
);

	logic                   valid_s1;
	logic [tkl_pkg::XW-1:0] x_s1;
	logic [tkl_pkg::YW-1:0] y_s1;
	logic                   advance;
	logic                   in_ready;
	logic                   step;

	tkl_pkg::zone_t         zone;
	tkl_pkg::code_keys_t    code;

	assign advance     = !result.valid || result.ready;
	assign in_ready    = !valid_s1 || advance;
	assign touch.ready = in_ready;
	assign step        = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= touch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (touch.valid && in_ready) begin
			x_s1 <= touch.touch_x;
			y_s1 <= touch.touch_y;
		end
	end

	tkl_cfg_regs u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.code    (code)
	);

	tkl_zone_decode u_decode (
		.touch_x (x_s1),
		.touch_y (y_s1),
		.zone    (zone)
	);

	tkl_lock_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.zone       (zone),
		.code       (code),
		.out_ready  (result.ready),
		.out_valid  (result.valid),
		.out_action (result.action),
		.out_key    (result.key_code),
		.out_count  (result.entered_count)
	);

endmodule

### rtl/tkl_cfg_regs.sv
module tkl_cfg_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [tkl_pkg::PaddrW-1:0]   paddr,
	input  logic [tkl_pkg::PdataW-1:0]   pwdata,
	output logic [tkl_pkg::PdataW-1:0]   prdata,
	output logic                         pready,
	output tkl_pkg::code_keys_t          code
);

	tkl_pkg::code_keys_t              code_q;
	logic                             wr_en;
	logic [tkl_pkg::CodeIdxW-1:0]     reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[tkl_pkg::PaddrW-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < tkl_pkg::NumCodeRegs; i++) begin
				code_q[tkl_pkg::CodeIdxW'(i)] <= tkl_pkg::code_reset(i);
			end
		end else if (wr_en) begin
			code_q[reg_idx] <= pwdata[tkl_pkg::KeyW-1:0];
		end
	end

	assign prdata = {{(tkl_pkg::PdataW - tkl_pkg::KeyW){1'b0}}, code_q[reg_idx]};
	assign code   = code_q;

endmodule

### rtl/tkl_zone_decode.sv
module tkl_zone_decode (
	input  logic [tkl_pkg::XW-1:0] touch_x,
	input  logic [tkl_pkg::YW-1:0] touch_y,
	output tkl_pkg::zone_t         zone
);

	logic [tkl_pkg::XW-1:0] ys;
	logic                   row_hit;
	logic [1:0]             row_idx;
	logic                   key_col;
	logic [1:0]             col_idx;
	logic                   btn_col;

	// row = (y + offset) / pitch, only rows 1..4 matter
	assign ys = {1'b0, touch_y} + tkl_pkg::XW'(tkl_pkg::RowOffset);

	always_comb begin
		row_hit = 1'b0;
		row_idx = '0;
		for (int r = 0; r < 4; r++) begin
			if (ys >= tkl_pkg::XW'(tkl_pkg::ZonePitch * (r + 1)) &&
				ys < tkl_pkg::XW'(tkl_pkg::ZonePitch * (r + 2))) begin
				row_hit = 1'b1;
				row_idx = 2'(r);
			end
		end
	end

	// key columns 1..3, button columns 5..7
	always_comb begin
		key_col = 1'b0;
		col_idx = '0;
		for (int c = 0; c < 3; c++) begin
			if (touch_x >= tkl_pkg::XW'(tkl_pkg::ZonePitch * (c + 1)) &&
				touch_x < tkl_pkg::XW'(tkl_pkg::ZonePitch * (c + 2))) begin
				key_col = 1'b1;
				col_idx = 2'(c);
			end
		end
	end

	assign btn_col = (touch_x >= tkl_pkg::XW'(tkl_pkg::ZonePitch * 5)) &&
		(touch_x < tkl_pkg::XW'(tkl_pkg::ZonePitch * 8));

	always_comb begin
		zone.key_hit = row_hit & key_col;
		zone.btn_hit = row_hit & btn_col;
		zone.btn     = tkl_pkg::btn_t'(row_idx);
		zone.key     = tkl_pkg::key_at(row_idx, col_idx);
	end

endmodule

### rtl/tkl_lock_core.sv
module tkl_lock_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  tkl_pkg::zone_t                  zone,
	input  tkl_pkg::code_keys_t             code,
	input  logic                            out_ready,
	output logic                            out_valid,
	output logic [tkl_pkg::ActW-1:0]        out_action,
	output logic [tkl_pkg::KeyW-1:0]        out_key,
	output logic [tkl_pkg::CountOutW-1:0]   out_count
);

	logic [tkl_pkg::CntW-1:0]                          count_q;
	logic [tkl_pkg::CodeLength-1:0][tkl_pkg::KeyW-1:0] slots_q;

	tkl_pkg::act_t              act_d;
	logic [tkl_pkg::KeyW-1:0]   key_d;
	logic [tkl_pkg::CntW-1:0]   count_d;
	logic                       wr_en;
	logic                       match;
	logic [tkl_pkg::KeyW-1:0]   exp_key;
	logic [tkl_pkg::KeyW-1:0]   digit;

	tkl_pkg::act_t                  act_q;
	logic [tkl_pkg::KeyW-1:0]       key_q;
	logic [tkl_pkg::CountOutW-1:0]  res_count_q;
	logic                           valid_q;

	// buffer compare against the code; fixed digits follow the registers
	always_comb begin
		match   = (count_q == tkl_pkg::CntW'(tkl_pkg::CodeLength));
		digit   = tkl_pkg::ExtraDigitStart;
		exp_key = '0;
		for (int k = 0; k < tkl_pkg::CodeLength; k++) begin
			if (k < tkl_pkg::NumCodeRegs) begin
				exp_key = code[tkl_pkg::CodeIdxW'(k)];
			end else begin
				exp_key = digit;
				digit   = (digit == 4'd9) ? 4'd0 : digit + 4'd1;
			end
			if (slots_q[tkl_pkg::IdxW'(k)] != exp_key) begin
				match = 1'b0;
			end
		end
	end

	always_comb begin
		act_d   = tkl_pkg::ACT_IGNORED;
		key_d   = '0;
		count_d = count_q;
		wr_en   = 1'b0;
		if (zone.key_hit) begin
			key_d = zone.key;
			if (count_q < tkl_pkg::CntW'(tkl_pkg::CodeLength)) begin
				wr_en   = 1'b1;
				count_d = count_q + 1'b1;
				act_d   = tkl_pkg::ACT_STORED;
			end
		end else if (zone.btn_hit) begin
			unique case (zone.btn)
				tkl_pkg::BTN_QUIT: begin
					count_d = '0;
					act_d   = tkl_pkg::ACT_QUIT;
				end
				tkl_pkg::BTN_DELETE: begin
					if (count_q != '0) begin
						count_d = count_q - 1'b1;
					end
					act_d = tkl_pkg::ACT_DELETE;
				end
				tkl_pkg::BTN_CLEAR: begin
					count_d = '0;
					act_d   = tkl_pkg::ACT_CLEAR;
				end
				tkl_pkg::BTN_CONFIRM: begin
					count_d = '0;
					act_d   = match ? tkl_pkg::ACT_CORRECT : tkl_pkg::ACT_WRONG;
				end
				default: begin
					act_d = tkl_pkg::ACT_IGNORED;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (step) begin
			count_q <= count_d;
		end
	end

	always_ff @(posedge clk) begin
		if (step && wr_en) begin
			slots_q[count_q[tkl_pkg::IdxW-1:0]] <= zone.key;
		end
	end

	// result register, a held result stalls the step
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (step) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			act_q       <= act_d;
			key_q       <= key_d;
			res_count_q <= tkl_pkg::CountOutW'(count_d);
		end
	end

	assign out_valid  = valid_q;
	assign out_action = act_q;
	assign out_key    = key_q;
	assign out_count  = res_count_q;

`ifndef SYNTH
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= tkl_pkg::CntW'(tkl_pkg::CodeLength))
		else $error("entry count above code length");

	a_store_inc: assert property (@(posedge clk) disable iff (!arst_n)
		step && act_d == tkl_pkg::ACT_STORED |=> count_q == $past(count_q) + 1'b1)
		else $error("stored key did not advance the count");

	a_result_count: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q |-> res_count_q == tkl_pkg::CountOutW'(count_q))
		else $error("shown count differs from buffer state");

	a_correct_full: assert property (@(posedge clk) disable iff (!arst_n)
		step && act_d == tkl_pkg::ACT_CORRECT |-> count_q == tkl_pkg::CntW'(tkl_pkg::CodeLength))
		else $error("correct reported with a partial buffer");

	a_no_step_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !out_ready |-> !step)
		else $error("step while a result is held");
`endif

endmodule

### tb/touch_keypad_code_lock_top_test.sv
module touch_keypad_code_lock_top_test;
	import tkl_pkg::*;

	typedef enum int {
		REG_CODE_FIRST  = 0,
		REG_CODE_SECOND = 1,
		REG_CODE_THIRD  = 2,
		REG_CODE_FOURTH = 3
	} code_reg_t;

	typedef struct packed {
		logic [XW-1:0] x;
		logic [YW-1:0] y;
	} point_t;

	typedef struct packed {
		act_t                 action;
		logic [KeyW-1:0]      key;
		logic [CountOutW-1:0] count;
	} lock_result_t;

	class lock_scoreboard;
		logic [KeyW-1:0] code_key [NumCodeRegs];
		logic [KeyW-1:0] slot [CodeLength];
		int unsigned held;
		lock_result_t expected_q[$];
		int errors;

		function new();
			for (int i = 0; i < NumCodeRegs; i++) begin
				code_key[i] = KeyW'(i + 1);
			end
			held = 0;
			errors = 0;
		endfunction

		function void set_code(int idx, logic [KeyW-1:0] value);
			if (idx < NumCodeRegs) begin
				code_key[idx] = value;
			end
		endfunction

		function logic [KeyW-1:0] code_at(int unsigned pos);
			if (pos < NumCodeRegs) begin
				return code_key[pos];
			end
			return KeyW'((pos + 1) % 10);
		endfunction

		function int pending();
			return expected_q.size();
		endfunction

		function void note_touch(point_t p);
			int unsigned col;
			int unsigned row;
			bit match;
			lock_result_t res;
			col = p.x / ZonePitch;
			row = (p.y + RowOffset) / ZonePitch;
			res.action = ACT_IGNORED;
			res.key = '0;
			if (row >= 1 && row <= 4) begin
				if (col >= 1 && col <= 3) begin
					if (row == 4) begin
						res.key = (col == 1) ? KeyStar : (col == 2) ? 4'd0 : KeyHash;
					end else begin
						res.key = KeyW'((row - 1) * 3 + col);
					end
					if (held < CodeLength) begin
						slot[held] = res.key;
						held++;
						res.action = ACT_STORED;
					end
				end else if (col >= 5 && col <= 7) begin
					case (btn_t'(row - 1))
						BTN_QUIT: begin
							held = 0;
							res.action = ACT_QUIT;
						end
						BTN_DELETE: begin
							if (held > 0) held--;
							res.action = ACT_DELETE;
						end
						BTN_CLEAR: begin
							held = 0;
							res.action = ACT_CLEAR;
						end
						default: begin
							match = (held == CodeLength);
							for (int k = 0; k < CodeLength; k++) begin
								if (match && slot[k] != code_at(k)) match = 0;
							end
							res.action = match ? ACT_CORRECT : ACT_WRONG;
							held = 0;
						end
					endcase
				end
			end
			res.count = CountOutW'(held);
			expected_q.push_back(res);
		endfunction

		function void check_result(logic [ActW-1:0] action, logic [KeyW-1:0] key,
			logic [CountOutW-1:0] count);
			lock_result_t want;
			if (expected_q.size() == 0) begin
				$error("result with no touch pending: action %0d key_code %0d entered_count %0d",
					action, key, count);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (action !== want.action) begin
				$error("action: expected %0d, got %0d", want.action, action);
				errors++;
			end
			if (key !== want.key) begin
				$error("key_code: expected %0d, got %0d", want.key, key);
				errors++;
			end
			if (count !== want.count) begin
				$error("entered_count: expected %0d, got %0d", want.count, count);
				errors++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [PaddrW-1:0] paddr;
	logic [PdataW-1:0] pwdata;
	logic [PdataW-1:0] prdata;
	logic pready;

	tkl_touch_if touch_ch ();
	tkl_result_if result_ch ();

	lock_scoreboard sb = new();
	bit steady;
	int sent;

	touch_keypad_code_lock_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.touch   (touch_ch),
		.result  (result_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	always #1 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (steady) return 0;
		if (r < 55) return 0;
		if (r < 85) return $urandom_range(1, 3);
		if (r < 97) return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	function automatic point_t key_spot(int k);
		int row;
		int col;
		point_t p;
		if (k == KeyStar) begin
			row = 4;
			col = 1;
		end else if (k == 0) begin
			row = 4;
			col = 2;
		end else if (k == KeyHash) begin
			row = 4;
			col = 3;
		end else begin
			row = (k - 1) / 3 + 1;
			col = (k - 1) % 3 + 1;
		end
		p.x = XW'(col * ZonePitch + $urandom_range(0, ZonePitch - 1));
		p.y = YW'(row * ZonePitch - RowOffset + $urandom_range(0, ZonePitch - 1));
		return p;
	endfunction

	function automatic point_t button_spot(btn_t b);
		point_t p;
		p.x = XW'($urandom_range(5, 7) * ZonePitch + $urandom_range(0, ZonePitch - 1));
		p.y = YW'((int'(b) + 1) * ZonePitch - RowOffset + $urandom_range(0, ZonePitch - 1));
		return p;
	endfunction

	// points that fall in no zone: the gap columns or the rows above and below
	function automatic point_t dead_spot();
		point_t p;
		p.x = XW'($urandom_range(0, 799));
		p.y = YW'($urandom_range(0, 479));
		case ($urandom_range(0, 4))
			0: p.x = XW'($urandom_range(0, 89));
			1: p.x = XW'($urandom_range(360, 449));
			2: p.x = XW'($urandom_range(720, 799));
			3: p.y = YW'($urandom_range(0, 74));
			default: p.y = YW'($urandom_range(435, 479));
		endcase
		return p;
	endfunction

	task automatic send_touch(point_t p);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			touch_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		touch_ch.valid <= 1'b1;
		touch_ch.touch_x <= p.x;
		touch_ch.touch_y <= p.y;
		@(posedge clk);
		while (!touch_ch.ready) @(posedge clk);
		sb.note_touch(p);
		sent++;
	endtask

	task automatic press_key(int k);
		send_touch(key_spot(k));
	endtask

	task automatic press_button(btn_t b);
		send_touch(button_spot(b));
	endtask

	task automatic write_code_reg(code_reg_t idx, logic [KeyW-1:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= PaddrW'(int'(idx) * 4);
		pwdata <= PdataW'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		sb.set_code(int'(idx), value);
	endtask

	task automatic write_code(logic [KeyW-1:0] a, logic [KeyW-1:0] b,
		logic [KeyW-1:0] c, logic [KeyW-1:0] d);
		write_code_reg(REG_CODE_FIRST, a);
		write_code_reg(REG_CODE_SECOND, b);
		write_code_reg(REG_CODE_THIRD, c);
		write_code_reg(REG_CODE_FOURTH, d);
	endtask

	// drain every pending result, then cover the two-stage pipeline
	task automatic settle();
		touch_ch.valid <= 1'b0;
		while (sb.pending() > 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// a code entry attempt, mostly right, with retyped keys and stray touches
	task automatic try_code();
		logic [KeyW-1:0] want;
		if ($urandom_range(0, 1)) press_button(BTN_CLEAR);
		for (int pos = 0; pos < CodeLength; pos++) begin
			if ($urandom_range(0, 11) == 0) begin
				press_key($urandom_range(0, 11));
				press_button(BTN_DELETE);
			end
			if ($urandom_range(0, 19) == 0) send_touch(dead_spot());
			want = sb.code_at(pos);
			if (want > KeyHash || $urandom_range(0, 9) == 0) want = KeyW'($urandom_range(0, 11));
			press_key(want);
		end
		if ($urandom_range(0, 9) == 0) press_key($urandom_range(0, 11));
		press_button(BTN_CONFIRM);
	endtask

	task automatic run_random(int n);
		int target;
		int r;
		point_t p;
		target = sent + n;
		while (sent < target) begin
			r = $urandom_range(0, 99);
			if (r < 55) begin
				try_code();
			end else if (r < 70) begin
				press_key($urandom_range(0, 11));
			end else if (r < 85) begin
				press_button(btn_t'($urandom_range(0, 3)));
			end else if (r < 93) begin
				send_touch(dead_spot());
			end else begin
				p.x = XW'($urandom_range(0, 799));
				p.y = YW'($urandom_range(0, 479));
				send_touch(p);
			end
		end
	endtask

	task automatic run_directed();
		send_touch('{x: 10'd0, y: 9'd0});
		send_touch('{x: 10'd799, y: 9'd479});
		press_button(BTN_DELETE);
		// reset code, then a fifth key against a full buffer
		press_key(1);
		press_key(2);
		press_key(3);
		press_key(4);
		press_key(5);
		press_button(BTN_CONFIRM);
		press_key(6);
		press_key(7);
		press_key(8);
		press_key(9);
		press_key(KeyStar);
		press_button(BTN_CONFIRM);
		press_key(0);
		press_key(KeyHash);
		press_button(BTN_DELETE);
		press_button(BTN_CLEAR);
		press_key(0);
		press_button(BTN_QUIT);
		// zone edges
		send_touch('{x: 10'd89, y: 9'd74});
		send_touch('{x: 10'd90, y: 9'd75});
		send_touch('{x: 10'd359, y: 9'd434});
		send_touch('{x: 10'd360, y: 9'd435});
		send_touch('{x: 10'd719, y: 9'd434});
	endtask

	// result side: random stalls, none while steady
	initial begin
		int stall_left;
		stall_left = 0;
		result_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (stall_left > 0) begin
				result_ch.ready <= 1'b0;
				stall_left--;
			end else begin
				result_ch.ready <= 1'b1;
				if (!steady && $urandom_range(0, 99) < 15) stall_left = pick_gap();
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && result_ch.valid && result_ch.ready) begin
			sb.check_result(result_ch.action, result_ch.key_code, result_ch.entered_count);
		end
	end

	initial begin
		arst_n <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		touch_ch.valid <= 1'b0;
		touch_ch.touch_x <= '0;
		touch_ch.touch_y <= '0;
		steady = 0;
		sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		run_directed();
		run_random(100);
		settle();

		for (int phase = 1; phase < 8; phase++) begin
			case (phase)
				1: write_code(4'd0, 4'd0, 4'd0, 4'd0);
				2: write_code(KeyHash, KeyHash, KeyHash, KeyHash);
				3: write_code(KeyStar, 4'd0, KeyHash, 4'd9);
				// codes above hash never match
				4: write_code(4'd15, 4'd12, 4'd3, 4'd4);
				5: write_code(4'd13, 4'd14, 4'd15, 4'd12);
				default: write_code(KeyW'($urandom_range(0, 11)), KeyW'($urandom_range(0, 11)),
					KeyW'($urandom_range(0, 11)), KeyW'($urandom_range(0, 11)));
			endcase
			steady = ($urandom_range(0, 3) == 0);
			run_random(100);
			settle();
		end

		steady = 0;
		repeat (10) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

	initial begin
		#2000000;
		$display("DONE: errors detected");
		$finish;
	end

endmodule
